// ----- rtl/core/ifac_pkg.sv -----
// Package for the intrusion and fire alarm controller: types, codes and reset values.
package ifac_pkg;

  typedef enum logic [1:0] {
    MODE_DISARMED = 2'd0,
    MODE_ARMED    = 2'd1,
    MODE_DOOR     = 2'd2,
    MODE_FIRE     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_ARM    = 2'd1,
    KIND_DISARM = 2'd2,
    KIND_RESET  = 2'd3
  } kind_e;

  localparam logic [1:0] TONE_SILENT = 2'd0;
  localparam logic [1:0] TONE_DOOR   = 2'd1;
  localparam logic [1:0] TONE_FIRE   = 2'd2;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_DOOR_ALARM = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ALARM_MAX  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_FIRE_BEEP  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DOOR_BEEP  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_BLINK      = 3'd5;

  localparam logic [15:0] DOOR_ALARM_RST = 16'd2000;
  localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [15:0] ALARM_MAX_RST  = 16'd30000;
  localparam logic [15:0] FIRE_BEEP_RST  = 16'd200;
  localparam logic [15:0] DOOR_BEEP_RST  = 16'd500;
  localparam logic [15:0] BLINK_RST      = 16'd300;

  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  typedef struct packed {
    mode_e       mode;
    logic        door_is_open;
    logic [1:0]  tone_select;
    logic        led_red;
    logic        led_green;
    logic        led_blue;
    logic [15:0] intrusions;
    logic        arm_refused;
  } res_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == TICK_MAX) ? v : v + 16'd1;
  endfunction

endpackage

// ----- rtl/core/intrusion_fire_alarm_controller_top.sv -----
// Top level of the intrusion and fire alarm controller.
// One beat on the input channel is one time tick; every tick yields exactly one result beat.
// A tick is taken every clock cycle unless the buffer is full: the whole tick update (counters,
// command, door debounce, alarm timing, LEDs) is combinational logic from the state registers
// into a two-entry result buffer, so a result appears in the cycle after its tick and the input
// keeps flowing until two results wait downstream. The input stalls only when both buffer
// entries are full. Configuration writes are always taken (ready tied high) and should be
// issued while idle; indexes beyond five are ignored.
module intrusion_fire_alarm_controller_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   kind_i,
  input  logic                         door_sample_i,
  input  logic                         flame_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   mode_o,
  output logic                         door_is_open_o,
  output logic [1:0]                   tone_select_o,
  output logic                         led_red_o,
  output logic                         led_green_o,
  output logic                         led_blue_o,
  output logic [15:0]                  intrusions_o,
  output logic                         arm_refused_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ifac_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]                  cfg_data_i
);
  import ifac_pkg::*;

  // configuration
  logic [15:0] door_alarm_q, debounce_q, alarm_max_q, fire_beep_q, door_beep_q, blink_q;

  // tick state
  mode_e       mode_q, mode_d;
  logic        door_q, door_d;
  logic        prev_q, prev_d;
  logic [15:0] stable_q, stable_d;
  logic [15:0] open_q, open_d;
  logic [15:0] alarm_q, alarm_d;
  logic [15:0] beep_q, beep_d;
  logic        buzz_q, buzz_d;
  logic [15:0] blinkc_q, blinkc_d;
  logic        blph_q, blph_d;
  logic [15:0] intr_q, intr_d;
  logic        refused_d;

  // result buffer
  res_t        res_d;
  res_t        buf_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        in_acc, out_acc;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (cnt_q == 2'd2);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_acc     = out_valid_o & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      door_alarm_q <= DOOR_ALARM_RST;
      debounce_q   <= DEBOUNCE_RST;
      alarm_max_q  <= ALARM_MAX_RST;
      fire_beep_q  <= FIRE_BEEP_RST;
      door_beep_q  <= DOOR_BEEP_RST;
      blink_q      <= BLINK_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_DOOR_ALARM: door_alarm_q <= cfg_data_i;
        REG_DEBOUNCE:   debounce_q   <= cfg_data_i;
        REG_ALARM_MAX:  alarm_max_q  <= cfg_data_i;
        REG_FIRE_BEEP:  fire_beep_q  <= cfg_data_i;
        REG_DOOR_BEEP:  door_beep_q  <= cfg_data_i;
        REG_BLINK:      blink_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // one tick of the controller
  always_comb begin
    logic [15:0] iv;
    iv        = door_beep_q;
    refused_d = 1'b0;
    mode_d    = mode_q;
    door_d    = door_q;
    buzz_d    = buzz_q;
    blph_d    = blph_q;
    intr_d    = intr_q;
    stable_d  = sat_inc(stable_q);
    open_d    = sat_inc(open_q);
    alarm_d   = sat_inc(alarm_q);
    beep_d    = sat_inc(beep_q);
    blinkc_d  = sat_inc(blinkc_q);
    prev_d    = door_sample_i;

    unique case (kind_e'(kind_i))
      KIND_ARM: begin
        if (mode_d == MODE_DISARMED) begin
          mode_d = MODE_ARMED;
          door_d = 1'b0;
        end else begin
          refused_d = 1'b1;
        end
      end
      KIND_DISARM, KIND_RESET: begin
        door_d = 1'b0;
        buzz_d = 1'b0;
        blph_d = 1'b0;
        mode_d = MODE_DISARMED;
        if (kind_e'(kind_i) == KIND_RESET) intr_d = '0;
      end
      KIND_NONE: ;
    endcase

    if (flame_sample_i && mode_d == MODE_ARMED) begin
      mode_d  = MODE_FIRE;
      alarm_d = '0;
    end

    if (mode_d == MODE_ARMED) begin
      if (door_sample_i != prev_q) stable_d = '0;
      if (stable_d > debounce_q) begin
        if (door_sample_i && !door_d) begin
          door_d = 1'b1;
          open_d = '0;
        end else if (!door_sample_i && door_d) begin
          door_d = 1'b0;
        end
      end
      if (door_d && open_d > door_alarm_q) begin
        mode_d  = MODE_DOOR;
        alarm_d = '0;
        intr_d  = sat_inc(intr_d);
      end
    end else begin
      door_d = door_sample_i;
    end

    if (mode_d == MODE_DOOR || mode_d == MODE_FIRE) begin
      iv = (mode_d == MODE_FIRE) ? fire_beep_q : door_beep_q;
      if (beep_d > iv) begin
        buzz_d = ~buzz_d;
        beep_d = '0;
      end
      if (alarm_d > alarm_max_q) begin
        door_d = 1'b0;
        buzz_d = 1'b0;
        blph_d = 1'b0;
        mode_d = MODE_DISARMED;
      end
    end

    if ((mode_d == MODE_DOOR || mode_d == MODE_FIRE) && blinkc_d > blink_q) begin
      blph_d   = ~blph_d;
      blinkc_d = '0;
    end
  end

  // result beat, derived from the next state
  always_comb begin
    res_d.mode         = mode_d;
    res_d.door_is_open = door_d;
    res_d.intrusions   = intr_d;
    res_d.arm_refused  = refused_d;
    res_d.tone_select  = TONE_SILENT;
    unique case (mode_d)
      MODE_DISARMED: begin
        res_d.led_red   = 1'b1;
        res_d.led_green = 1'b1;
        res_d.led_blue  = 1'b0;
      end
      MODE_ARMED: begin
        res_d.led_red   = 1'b0;
        res_d.led_green = ~door_d;
        res_d.led_blue  = door_d;
      end
      MODE_DOOR, MODE_FIRE: begin
        res_d.led_red   = blph_d;
        res_d.led_green = 1'b0;
        res_d.led_blue  = 1'b0;
        if (buzz_d) res_d.tone_select = (mode_d == MODE_FIRE) ? TONE_FIRE : TONE_DOOR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_DISARMED;
      door_q   <= 1'b0;
      prev_q   <= 1'b0;
      stable_q <= '0;
      open_q   <= '0;
      alarm_q  <= '0;
      beep_q   <= '0;
      buzz_q   <= 1'b0;
      blinkc_q <= '0;
      blph_q   <= 1'b0;
      intr_q   <= '0;
    end else if (in_acc) begin
      mode_q   <= mode_d;
      door_q   <= door_d;
      prev_q   <= prev_d;
      stable_q <= stable_d;
      open_q   <= open_d;
      alarm_q  <= alarm_d;
      beep_q   <= beep_d;
      buzz_q   <= buzz_d;
      blinkc_q <= blinkc_d;
      blph_q   <= blph_d;
      intr_q   <= intr_d;
    end
  end

  // two-entry result buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (in_acc)  wr_ptr_q <= ~wr_ptr_q;
      if (out_acc) rd_ptr_q <= ~rd_ptr_q;
      if (in_acc && !out_acc)      cnt_q <= cnt_q + 2'd1;
      else if (!in_acc && out_acc) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) buf_q[wr_ptr_q] <= res_d;
  end

  assign mode_o         = buf_q[rd_ptr_q].mode;
  assign door_is_open_o = buf_q[rd_ptr_q].door_is_open;
  assign tone_select_o  = buf_q[rd_ptr_q].tone_select;
  assign led_red_o      = buf_q[rd_ptr_q].led_red;
  assign led_green_o    = buf_q[rd_ptr_q].led_green;
  assign led_blue_o     = buf_q[rd_ptr_q].led_blue;
  assign intrusions_o   = buf_q[rd_ptr_q].intrusions;
  assign arm_refused_o  = buf_q[rd_ptr_q].arm_refused;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer count out of range");

  a_ptr_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
    else $error("buffer pointers disagree with count");

  a_phase_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_DISARMED || mode_q == MODE_ARMED) |-> (!buzz_q && !blph_q))
    else $error("buzzer or blink phase set outside an alarm");

  a_intr_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (intr_q == TICK_MAX && in_acc && kind_i != KIND_RESET) |=> (intr_q == TICK_MAX))
    else $error("intrusion count wrapped");

  a_refused_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && kind_i == KIND_ARM && mode_q == MODE_DISARMED) |=>
      !buf_q[$past(wr_ptr_q)].arm_refused)
    else $error("arm refused while disarmed");
`endif

endmodule

// ----- test/intrusion_fire_alarm_controller_top_tb.sv -----
// Self-checking testbench for the intrusion and fire alarm controller top level.
module intrusion_fire_alarm_controller_top_tb;
  import ifac_pkg::*;

  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned PHASES      = 9;
  localparam int unsigned PHASE_TICKS = 150;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [1:0]          kind_i;
  logic                door_sample_i;
  logic                flame_sample_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [1:0]          mode_o;
  logic                door_is_open_o;
  logic [1:0]          tone_select_o;
  logic                led_red_o;
  logic                led_green_o;
  logic                led_blue_o;
  logic [15:0]         intrusions_o;
  logic                arm_refused_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [15:0]         cfg_data_i;

  intrusion_fire_alarm_controller_top dut (.*);

  typedef struct {
    kind_e kind;
    logic  door;
    logic  flame;
    logic  typed;
    res_t  want;
    logic  reconfig;
  } row_t;

  // predictor state
  logic [15:0] reg_val [0:5];
  mode_e       p_mode;
  logic        door_open, prev_door, buzz_ph, blink_ph;
  logic [15:0] stable_cnt, open_cnt, alarm_cnt, beep_cnt, blink_cnt, intr_total;

  res_t        tick_results_q [$];
  row_t        plan [$];
  logic        hand_on;
  res_t        hand_res;
  logic        idle_on;
  int unsigned err_count, ticks_taken, results_seen, reg_writes, quiet_cycles;
  int unsigned door_alarms, fire_alarms, timeouts, refused_arms;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] sat_up(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic res_t outcome(mode_e m, logic d, logic [1:0] t, logic r, logic g,
                                   logic b, logic [15:0] n, logic ar);
    res_t o;
    o.mode = m;
    o.door_is_open = d;
    o.tone_select = t;
    o.led_red = r;
    o.led_green = g;
    o.led_blue = b;
    o.intrusions = n;
    o.arm_refused = ar;
    return o;
  endfunction

  // One tick of the alarm controller; updates the shadow state and returns the beat.
  function automatic res_t advance_tick(kind_e kind, logic door, logic flame);
    res_t        r;
    logic        refused;
    logic [15:0] iv;
    refused    = 1'b0;
    stable_cnt = sat_up(stable_cnt);
    open_cnt   = sat_up(open_cnt);
    alarm_cnt  = sat_up(alarm_cnt);
    beep_cnt   = sat_up(beep_cnt);
    blink_cnt  = sat_up(blink_cnt);

    case (kind)
      KIND_ARM: begin
        if (p_mode == MODE_DISARMED) begin
          p_mode = MODE_ARMED;
          door_open = 1'b0;
        end else begin
          refused = 1'b1;
          refused_arms++;
        end
      end
      KIND_DISARM, KIND_RESET: begin
        door_open = 1'b0;
        buzz_ph = 1'b0;
        blink_ph = 1'b0;
        p_mode = MODE_DISARMED;
        if (kind == KIND_RESET) intr_total = '0;
      end
      default: ;
    endcase

    if (flame && p_mode == MODE_ARMED) begin
      p_mode = MODE_FIRE;
      alarm_cnt = '0;
      fire_alarms++;
    end

    if (p_mode == MODE_ARMED) begin
      if (door != prev_door) stable_cnt = '0;
      if (stable_cnt > reg_val[REG_DEBOUNCE]) begin
        if (door && !door_open) begin
          door_open = 1'b1;
          open_cnt = '0;
        end else if (!door && door_open) begin
          door_open = 1'b0;
        end
      end
      if (door_open && open_cnt > reg_val[REG_DOOR_ALARM]) begin
        p_mode = MODE_DOOR;
        alarm_cnt = '0;
        intr_total = sat_up(intr_total);
        door_alarms++;
      end
    end else begin
      door_open = door;
    end
    prev_door = door;

    if (p_mode == MODE_DOOR || p_mode == MODE_FIRE) begin
      iv = (p_mode == MODE_FIRE) ? reg_val[REG_FIRE_BEEP] : reg_val[REG_DOOR_BEEP];
      if (beep_cnt > iv) begin
        buzz_ph = ~buzz_ph;
        beep_cnt = '0;
      end
      if (alarm_cnt > reg_val[REG_ALARM_MAX]) begin
        door_open = 1'b0;
        buzz_ph = 1'b0;
        blink_ph = 1'b0;
        p_mode = MODE_DISARMED;
        timeouts++;
      end
    end

    if ((p_mode == MODE_DOOR || p_mode == MODE_FIRE) && blink_cnt > reg_val[REG_BLINK]) begin
      blink_ph = ~blink_ph;
      blink_cnt = '0;
    end

    case (p_mode)
      MODE_DISARMED: r = outcome(p_mode, door_open, TONE_SILENT, 1'b1, 1'b1, 1'b0,
                                 intr_total, refused);
      MODE_ARMED:    r = outcome(p_mode, door_open, TONE_SILENT, 1'b0, ~door_open, door_open,
                                 intr_total, refused);
      default:       r = outcome(p_mode, door_open,
                                 !buzz_ph ? TONE_SILENT :
                                 (p_mode == MODE_FIRE) ? TONE_FIRE : TONE_DOOR,
                                 blink_ph, 1'b0, 1'b0, intr_total, refused);
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    err_count++;
    if (err_count <= 40)
      $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
  endtask

  task automatic check_result(res_t got, res_t want);
    if (got.mode !== want.mode) report_mismatch("mode", got.mode, want.mode);
    if (got.door_is_open !== want.door_is_open)
      report_mismatch("door_is_open", got.door_is_open, want.door_is_open);
    if (got.tone_select !== want.tone_select)
      report_mismatch("tone_select", got.tone_select, want.tone_select);
    if (got.led_red !== want.led_red) report_mismatch("led_red", got.led_red, want.led_red);
    if (got.led_green !== want.led_green)
      report_mismatch("led_green", got.led_green, want.led_green);
    if (got.led_blue !== want.led_blue) report_mismatch("led_blue", got.led_blue, want.led_blue);
    if (got.intrusions !== want.intrusions)
      report_mismatch("intrusions", got.intrusions, want.intrusions);
    if (got.arm_refused !== want.arm_refused)
      report_mismatch("arm_refused", got.arm_refused, want.arm_refused);
  endtask

  // Tick acceptance feeds the predictor; result beats are checked in order.
  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        want = advance_tick(kind_e'(kind_i), door_sample_i, flame_sample_i);
        if (hand_on) want = hand_res;
        tick_results_q.push_back(want);
        ticks_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        got = {mode_o, door_is_open_o, tone_select_o, led_red_o, led_green_o, led_blue_o,
               intrusions_o, arm_refused_o};
        results_seen++;
        if (tick_results_q.size() == 0) begin
          report_mismatch("beat with nothing pending, mode", got.mode, 0);
        end else begin
          want = tick_results_q.pop_front();
          check_result(got, want);
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: %0d cycles without a beat, %0d results pending",
                 quiet_cycles, tick_results_q.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // Receiver stall bursts.
  initial begin
    int n;
    out_stall_i = 1'b0;
    forever begin
      n = $urandom_range(1, 10);
      if (idle_on && $urandom_range(0, 2) == 0)
        repeat (n) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      else
        repeat (n) begin
          @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
    end
  end

  task automatic sender_gap();
    int n;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 10);
      repeat (n) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
    end
  endtask

  task automatic send_tick(kind_e k, logic d, logic f, logic typed, res_t want);
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    kind_i         <= k;
    door_sample_i  <= d;
    flame_sample_i <= f;
    hand_on  = typed;
    hand_res = want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Sender holds off until every pending result beat has come back.
  task automatic park_and_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx <= REG_BLINK) reg_val[idx] = data;
    reg_writes++;
  endtask

  function automatic logic [15:0] pick_reg_value();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(0, 25));
    endcase
  endfunction

  task automatic add_row(kind_e k, logic d, logic f, logic typed, res_t want, logic reconfig);
    row_t r;
    r.kind = k;
    r.door = d;
    r.flame = f;
    r.typed = typed;
    r.want = want;
    r.reconfig = reconfig;
    plan.push_back(r);
  endtask

  initial begin
    kind_e       k;
    logic        door_val, flame_val, noisy;
    int unsigned run_left, pick;
    logic [15:0] v;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = KIND_NONE;
    door_sample_i = 1'b0;
    flame_sample_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_DOOR_ALARM;
    cfg_data_i = '0;
    hand_on = 1'b0;
    hand_res = '0;
    idle_on = 1'b1;
    err_count = 0;
    ticks_taken = 0;
    results_seen = 0;
    reg_writes = 0;
    quiet_cycles = 0;
    door_alarms = 0;
    fire_alarms = 0;
    timeouts = 0;
    refused_arms = 0;

    reg_val[REG_DOOR_ALARM] = DOOR_ALARM_RST;
    reg_val[REG_DEBOUNCE]   = DEBOUNCE_RST;
    reg_val[REG_ALARM_MAX]  = ALARM_MAX_RST;
    reg_val[REG_FIRE_BEEP]  = FIRE_BEEP_RST;
    reg_val[REG_DOOR_BEEP]  = DOOR_BEEP_RST;
    reg_val[REG_BLINK]      = BLINK_RST;
    p_mode = MODE_DISARMED;
    {door_open, prev_door, buzz_ph, blink_ph} = '0;
    {stable_cnt, open_cnt, alarm_cnt, beep_cnt, blink_cnt, intr_total} = '0;

    // Reset values first; flame is ignored and the door follows the sample while disarmed.
    add_row(KIND_NONE, 0, 0, 1, outcome(MODE_DISARMED, 0, TONE_SILENT, 1, 1, 0, 0, 0), 0);
    add_row(KIND_NONE, 1, 1, 1, outcome(MODE_DISARMED, 1, TONE_SILENT, 1, 1, 0, 0, 0), 0);
    add_row(KIND_DISARM, 0, 0, 1, outcome(MODE_DISARMED, 0, TONE_SILENT, 1, 1, 0, 0, 0), 0);
    add_row(KIND_RESET, 1, 0, 1, outcome(MODE_DISARMED, 1, TONE_SILENT, 1, 1, 0, 0, 0), 0);
    add_row(KIND_ARM, 0, 0, 1, outcome(MODE_ARMED, 0, TONE_SILENT, 0, 1, 0, 0, 0), 0);
    add_row(KIND_ARM, 0, 0, 1, outcome(MODE_ARMED, 0, TONE_SILENT, 0, 1, 0, 0, 1), 0);
    add_row(KIND_NONE, 0, 1, 1, outcome(MODE_FIRE, 0, TONE_SILENT, 0, 0, 0, 0, 0), 0);
    add_row(KIND_ARM, 1, 0, 0, '0, 0);
    add_row(KIND_DISARM, 0, 0, 1, outcome(MODE_DISARMED, 0, TONE_SILENT, 1, 1, 0, 0, 0), 0);
    // Short intervals: debounce, door alarm, beeps and blinks within a few ticks.
    add_row(KIND_ARM, 1, 0, 0, '0, 1);
    repeat (5) add_row(KIND_NONE, 1, 0, 0, '0, 0);
    add_row(KIND_ARM, 1, 0, 0, '0, 0);
    repeat (3) add_row(KIND_NONE, 0, 0, 0, '0, 0);
    add_row(KIND_NONE, 1, 1, 0, '0, 0);
    add_row(KIND_DISARM, 0, 0, 0, '0, 0);
    add_row(KIND_ARM, 0, 0, 0, '0, 0);
    add_row(KIND_NONE, 0, 1, 0, '0, 0);
    add_row(KIND_RESET, 0, 0, 1, outcome(MODE_DISARMED, 0, TONE_SILENT, 1, 1, 0, 0, 0), 0);
    add_row(KIND_NONE, 1, 0, 1, outcome(MODE_DISARMED, 1, TONE_SILENT, 1, 1, 0, 0, 0), 0);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].reconfig) begin
        park_and_drain();
        write_reg(REG_DOOR_ALARM, 16'd2);
        write_reg(REG_DEBOUNCE, 16'd1);
        write_reg(REG_ALARM_MAX, 16'd12);
        write_reg(REG_FIRE_BEEP, 16'd0);
        write_reg(REG_DOOR_BEEP, 16'd1);
        write_reg(REG_BLINK, 16'd0);
        write_reg(CfgIdxW'(6), 16'hA5A5);  // out of range, must be ignored
        write_reg(CfgIdxW'(7), 16'h5A5A);
        @(negedge clk_i);
        cfg_valid_i <= 1'b0;
      end
      sender_gap();
      send_tick(plan[i].kind, plan[i].door, plan[i].flame, plan[i].typed, plan[i].want);
    end

    run_left = 0;
    door_val = 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) idle_on = 1'b0;
      park_and_drain();
      for (int r = 0; r <= REG_BLINK; r++) begin
        v = (p == 0) ? 16'h0000 : (p == 1) ? 16'hFFFF : pick_reg_value();
        write_reg(CfgIdxW'(r), v);
      end
      if ($urandom_range(0, 1)) write_reg(CfgIdxW'($urandom_range(6, 7)), 16'($urandom));
      @(negedge clk_i);
      cfg_valid_i <= 1'b0;
      noisy = (p > 1) && ($urandom_range(0, 3) == 0);

      for (int n = 0; n < PHASE_TICKS; n++) begin
        if (n == PHASE_TICKS / 2 && idle_on) park_and_drain();
        pick = $urandom_range(0, 99);
        if (p_mode == MODE_DISARMED && pick < 15) k = KIND_ARM;
        else if (pick < 86) k = KIND_NONE;
        else if (pick < 91) k = KIND_ARM;
        else if (pick < 95) k = KIND_DISARM;
        else if (pick < 98) k = KIND_RESET;
        else k = kind_e'($urandom_range(0, 3));
        // door held in runs so the debounce passes; noisy phases chatter
        if (run_left == 0) begin
          door_val = 1'($urandom_range(0, 1));
          run_left = noisy ? $urandom_range(1, 2) : $urandom_range(1, 30);
        end
        run_left--;
        flame_val = noisy ? ($urandom_range(0, 4) == 0) : ($urandom_range(0, 49) == 0);
        sender_gap();
        send_tick(k, door_val, flame_val, 1'b0, '0);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("%0d ticks, %0d result beats checked, %0d register writes, %0d mismatches",
             ticks_taken, results_seen, reg_writes, err_count);
    $display("alarms raised: %0d door, %0d fire; %0d timed out; %0d arm commands refused",
             door_alarms, fire_alarms, timeouts, refused_arms);
    if (err_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
